// ===== rtl/core/hcpg_pkg.sv =====
// Shared constants for the Hermite curve point generator.
`timescale 1ns / 1ps
`default_nettype none

package hcpg_pkg;

  // Default sizing handed to the top level
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  // Configuration register widths and reset values
  localparam int NP_W       = 7;
  localparam int COLOR_W    = 24;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [NP_W-1:0]    NUM_POINTS_RST  = 7'd16;
  localparam logic [COLOR_W-1:0] PIXEL_COLOR_RST = 24'd0;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_POINTS  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_COLOR = 1'b1;

  // Fixed-point formats: t is unsigned Q1.16, weights are signed Q2.16 with headroom
  localparam int FRAC_W = 16;
  localparam int T_W    = 17;
  localparam int H_W    = 20;

  localparam logic [T_W-1:0]        T_ONE = 17'd65536;
  localparam logic signed [H_W-1:0] H_ONE = 20'sd65536;
  localparam logic [FRAC_W:0]       HALF  = 17'd32768;

endpackage : hcpg_pkg

`default_nettype wire

// ===== rtl/core/hermite_curve_point_generator.sv =====
// Cubic Hermite curve point generator: one item in, a run of curve pixels out.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: start/end points and tangents
//  m_*      | out | m_tvalid/m_tready  | m_tdata: pixel_x, pixel_y, pixel_rgb; m_tlast
//  cfg_*    | in  | cfg_we             | cfg_addr selects num_points or pixel_color
//
//  Each point passes through the radix-2 divider that forms t, the powers t^2 and t^3
//  on the shared multiplier, the weights, the eight multiply-accumulates of x and y,
//  and the idle state that holds the output beat through any output stall until taken.
//  An item occupies the block until its last point is taken; s_tready is low meanwhile.
//  An item with fewer than two points is accepted and dropped.
//  rst is synchronous and active high; it returns the block to idle and the registers
//  to 16 points and color zero.
`timescale 1ns / 1ps
`default_nettype none

module hermite_curve_point_generator #(
  parameter int MAX_POINTS = hcpg_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = hcpg_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input item beat
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // start_x, start_y, start_tan_x, start_tan_y, end_x, end_y, end_tan_x, end_tan_y
  input  wire logic [8*COORD_BITS-1:0]          s_tdata,
  // Output pixel beat
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // pixel_x, pixel_y, pixel_rgb, zero fill to whole bytes
  output logic [((2*COORD_BITS+hcpg_pkg::COLOR_W+7)/8)*8-1:0] m_tdata,
  output logic                                  m_tlast,
  // Configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [hcpg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [hcpg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NP_W    = hcpg_pkg::NP_W;
  localparam int T_W     = hcpg_pkg::T_W;
  localparam int H_W     = hcpg_pkg::H_W;
  localparam int FRAC_W  = hcpg_pkg::FRAC_W;
  localparam int COLOR_W = hcpg_pkg::COLOR_W;
  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int DIV_W   = IDX_W + 1;
  localparam int REM_W   = IDX_W + 2;
  localparam int STEP_W  = $clog2(T_W);
  localparam int MB_W    = (COORD_BITS > T_W + 1) ? COORD_BITS : T_W + 1;
  localparam int P_W     = H_W + MB_W;
  localparam int ACC_W   = P_W + 2;
  localparam int QW      = ACC_W - FRAC_W;
  localparam int OUT_W   = ((2*COORD_BITS + COLOR_W + 7) / 8) * 8;

  localparam logic [NP_W-1:0]   NP_MAX    = NP_W'(MAX_POINTS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(T_W - 1);
  localparam logic [3:0]        MAC_LAST  = 4'd9;
  localparam logic [QW-1:0]     LIM_P     = QW'((64'd1 << (COORD_BITS-1)) - 64'd1);
  localparam logic [QW-1:0]     LIM_N     = QW'(64'd1 << (COORD_BITS-1));

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_CUBE = 3'd4;
  localparam logic [2:0] S_CUBR = 3'd5;
  localparam logic [2:0] S_WGT  = 3'd6;
  localparam logic [2:0] S_MAC  = 3'd7;
  localparam logic [2:0] S_OUT_UNUSED = 3'd0;

  logic [2:0]              state;
  logic                    out_full;
  logic [IDX_W-1:0]        pt_idx;
  logic [IDX_W-1:0]        den;
  logic [STEP_W-1:0]       dstep;
  logic [3:0]              k;

  logic [NP_W-1:0]         num_points;
  logic [COLOR_W-1:0]      pixel_color;

  logic signed [COORD_BITS-1:0] crd [8];
  logic [REM_W-1:0]        rem;
  logic [T_W-1:0]          nlow;
  logic [T_W-1:0]          quo;
  logic [T_W-1:0]          t2;
  logic [T_W-1:0]          t3;
  logic signed [H_W-1:0]   hw [4];
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc;
  logic [COORD_BITS-1:0]   px;
  logic [COORD_BITS-1:0]   py;

  logic                    s_fire;
  logic                    m_fire;
  logic [NP_W-1:0]         np_eff;
  logic [IDX_W-1:0]        idx_next;
  logic [DIV_W-1:0]        dvsr;
  logic [REM_W-1:0]        trial;
  logic                    ge;
  logic signed [H_W-1:0]   mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic [2*T_W-1:0]        pw_rnd;
  logic signed [H_W-1:0]   ta;
  logic signed [H_W-1:0]   tb;
  logic signed [H_W-1:0]   tc;
  logic signed [ACC_W-1:0] prod_ext;

  // Round half away from zero, then saturate to the coordinate range
  function automatic logic [COORD_BITS-1:0] rnd_sat(input logic signed [ACC_W-1:0] s);
    logic             neg;
    logic [ACC_W-1:0] mag;
    logic [QW-1:0]    q;
    logic [COORD_BITS-1:0] r;
    neg = s[ACC_W-1];
    mag = (neg ? ~s : s) + (neg ? ACC_W'(hcpg_pkg::HALF) + ACC_W'(1) : ACC_W'(hcpg_pkg::HALF));
    q   = mag[ACC_W-1:FRAC_W];
    if (!neg && q > LIM_P) begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (neg && q > LIM_N) begin
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else if (neg) begin
      r = -q[COORD_BITS-1:0];
    end else begin
      r = q[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // Handshakes and clamped point count
  assign s_tready = (state == S_IDLE) && !out_full;
  assign m_tvalid = out_full;
  assign m_tlast  = (pt_idx == den);
  assign m_tdata  = OUT_W'({pixel_color, py, px});
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = out_full && m_tready;
  assign np_eff   = (num_points > NP_MAX) ? NP_MAX : num_points;
  assign idx_next = pt_idx + IDX_W'(1);
  assign dvsr     = {den, 1'b0};

  // One restoring divide step: t = (i*2^17 + den) / (2*den)
  assign trial = {rem[REM_W-2:0], nlow[T_W-1]};
  assign ge    = (trial >= REM_W'(dvsr));

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = $signed(H_W'(quo));
        mul_b = $signed(MB_W'(quo));
      end
      S_CUBE: begin
        mul_a = $signed(H_W'(t2));
        mul_b = $signed(MB_W'(quo));
      end
      S_MAC: begin
        mul_a = hw[k[1:0]];
        mul_b = MB_W'(crd[{k[0], k[1], k[2]}]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign pw_rnd   = prod[2*T_W-1:0] + (2*T_W)'(hcpg_pkg::HALF);
  assign ta       = $signed(H_W'(quo));
  assign tb       = $signed(H_W'(t2));
  assign tc       = $signed(H_W'(t3));
  assign prod_ext = ACC_W'(prod);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points  <= hcpg_pkg::NUM_POINTS_RST;
      pixel_color <= hcpg_pkg::PIXEL_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        hcpg_pkg::CFG_NUM_POINTS:  num_points  <= cfg_wdata[NP_W-1:0];
        hcpg_pkg::CFG_PIXEL_COLOR: pixel_color <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
      pt_idx   <= '0;
      dstep    <= '0;
      k        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_full) begin
            // Hold the beat until taken, then start the next point or finish
            if (m_tready) begin
              out_full <= 1'b0;
              if (pt_idx != den) begin
                pt_idx <= idx_next;
                dstep  <= '0;
                state  <= S_DIV;
              end
            end
          end else if (s_fire && np_eff >= NP_W'(2)) begin
            pt_idx <= '0;
            dstep  <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          dstep <= dstep + STEP_W'(1);
          if (dstep == STEP_LAST) begin
            state <= S_SQ;
          end
        end
        S_SQ:   state <= S_SQR;
        S_SQR:  state <= S_CUBE;
        S_CUBE: state <= S_CUBR;
        S_CUBR: state <= S_WGT;
        S_WGT: begin
          k     <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          k <= k + 4'd1;
          if (k == MAC_LAST) begin
            out_full <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: capture item, divide, powers, weights, multiply-accumulate
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (s_fire) begin
      den <= IDX_W'(np_eff - NP_W'(1));
      rem <= '0;
      nlow <= T_W'(IDX_W'(np_eff - NP_W'(1)));
      for (int j = 0; j < 8; j++) begin
        crd[j] <= s_tdata[j*COORD_BITS +: COORD_BITS];
      end
    end
    if (state == S_IDLE && m_fire && pt_idx != den) begin
      rem  <= REM_W'(idx_next);
      nlow <= T_W'(den);
    end
    case (state)
      S_DIV: begin
        rem  <= ge ? (trial - REM_W'(dvsr)) : trial;
        nlow <= {nlow[T_W-2:0], 1'b0};
        quo  <= {quo[T_W-2:0], ge};
      end
      S_SQR:  t2 <= pw_rnd[FRAC_W +: T_W];
      S_CUBR: t3 <= pw_rnd[FRAC_W +: T_W];
      S_WGT: begin
        hw[0] <= (tc <<< 1) - (tb + (tb <<< 1)) + hcpg_pkg::H_ONE;
        hw[1] <= (tb + (tb <<< 1)) - (tc <<< 1);
        hw[2] <= tc - (tb <<< 1) + ta;
        hw[3] <= tc - tb;
      end
      S_MAC: begin
        if (k inside {4'd1, 4'd5}) begin
          acc <= prod_ext;
        end else if (k inside {[4'd2:4'd4], [4'd6:4'd8]}) begin
          acc <= acc + prod_ext;
        end
        if (k == 4'd5) begin
          px <= rnd_sat(acc);
        end
        if (k == MAC_LAST) begin
          py <= rnd_sat(acc);
        end
      end
      default: ;
    endcase
  end

  // Divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < REM_W'(dvsr)))
    else $error("divider remainder out of range");

  // First point lands on t = 0, last point on t = 1.0
  a_t_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ && pt_idx == '0) |-> (quo == '0))
    else $error("first point t not zero");

  a_t_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ && pt_idx == den) |-> (quo == hcpg_pkg::T_ONE))
    else $error("last point t not one");

  // An accepted item with two or more points starts at point zero
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_fire && np_eff >= NP_W'(2)) |=> (state == S_DIV && pt_idx == '0))
    else $error("run did not start at point zero");

  // After the last beat of a run the block is ready again
  a_done: assert property (@(posedge clk) disable iff (rst)
    (m_fire && m_tlast) |=> s_tready)
    else $error("block not ready after final point");

  // Busy sequencer never shows an output beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_OUT_UNUSED) |-> !m_tvalid)
    else $error("output beat while computing");

endmodule : hermite_curve_point_generator

`default_nettype wire

// ===== bench/hermite_curve_point_generator_test.sv =====
// Testbench for the Hermite curve point generator: directed and random curves, self-checking.
`timescale 1ns / 1ps

module hermite_curve_point_generator_test;

  localparam int CW             = hcpg_pkg::COORD_BITS_DEF;
  localparam int PT_CAP         = hcpg_pkg::MAX_POINTS_DEF;
  localparam int NP_W           = hcpg_pkg::NP_W;
  localparam int COLOR_W        = hcpg_pkg::COLOR_W;
  localparam int CFG_ADDR_W     = hcpg_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W     = hcpg_pkg::CFG_DATA_W;
  localparam int OUT_W          = ((2*CW+COLOR_W+7)/8)*8;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_CAP      = 30;

  typedef logic signed [CW-1:0] coord_t;

  // Declared high field first so that start_x lands in the low bits of s_tdata
  typedef struct packed {
    coord_t end_tan_y;
    coord_t end_tan_x;
    coord_t end_y;
    coord_t end_x;
    coord_t start_tan_y;
    coord_t start_tan_x;
    coord_t start_y;
    coord_t start_x;
  } curve_t;

  typedef struct {
    coord_t               x;
    coord_t               y;
    logic [COLOR_W-1:0]   rgb;
    logic                 last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // start_x, start_y, start_tan_x, start_tan_y, end_x, end_y, end_tan_x, end_tan_y
  logic [8*CW-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // pixel_x, pixel_y, pixel_rgb
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local copy of the configuration registers
  logic [NP_W-1:0]       np_reg    = hcpg_pkg::NUM_POINTS_RST;
  logic [COLOR_W-1:0]    color_reg = hcpg_pkg::PIXEL_COLOR_RST;

  pixel_t pixel_q[$];
  int     tx_idle_pct  = 0;
  int     rx_stall_pct = 0;
  int     mismatches   = 0;
  int     curves_sent  = 0;
  int     pixels_seen  = 0;
  int     settings     = 0;
  int     quiet_cycles = 0;

  hermite_curve_point_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t ERROR pixel %0d %s: got %0d, want %0d", $time, pixels_seen, what, got, want);
    end
    mismatches++;
  endtask

  // Round half away from zero, then clamp to the signed coordinate range
  function automatic coord_t round_clamp(input longint s);
    longint r;
    if (s >= 0) begin
      r = (s + 32768) >>> 16;
    end else begin
      r = -((-s + 32768) >>> 16);
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return coord_t'(r);
  endfunction

  // Queue the pixels of one curve under the current configuration
  function automatic void predict_pixels(input curve_t c);
    longint unsigned n, den, t, t2, t3;
    longint a, b, q, h1, h2, h3, h4, sx, sy;
    pixel_t p;
    n = 64'(np_reg);
    if (n < 2) return;
    if (n > PT_CAP) n = PT_CAP;
    den = n - 1;
    for (longint unsigned i = 0; i < n; i++) begin
      t  = (i * 65536 * 2 + den) / (2 * den);
      t2 = (t * t + 32768) >> 16;
      t3 = (t2 * t + 32768) >> 16;
      a  = longint'(t);
      b  = longint'(t2);
      q  = longint'(t3);
      h1 = 2 * q - 3 * b + 65536;
      h2 = -2 * q + 3 * b;
      h3 = q - 2 * b + a;
      h4 = q - b;
      sx = h1 * longint'(c.start_x) + h2 * longint'(c.end_x)
         + h3 * longint'(c.start_tan_x) + h4 * longint'(c.end_tan_x);
      sy = h1 * longint'(c.start_y) + h2 * longint'(c.end_y)
         + h3 * longint'(c.start_tan_y) + h4 * longint'(c.end_tan_y);
      p.x    = round_clamp(sx);
      p.y    = round_clamp(sy);
      p.rgb  = color_reg;
      p.last = (i == den);
      pixel_q.push_back(p);
    end
  endfunction

  // Send one curve; valid stays high after the beat so a following send can reuse it
  task automatic send_curve(input curve_t c);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    predict_pixels(c);
    curves_sent++;
  endtask

  task automatic tx_stop();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; only bits [6:0] count for num_points
  task automatic set_config(input logic [CFG_DATA_W-1:0] np_word,
                            input logic [COLOR_W-1:0] color);
    cfg_we    <= 1'b1;
    cfg_addr  <= hcpg_pkg::CFG_NUM_POINTS;
    cfg_wdata <= np_word;
    @(posedge clk);
    np_reg    = np_word[NP_W-1:0];
    cfg_addr  <= hcpg_pkg::CFG_PIXEL_COLOR;
    cfg_wdata <= color;
    @(posedge clk);
    color_reg = color;
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // Bias toward the rails and small values, keep plenty of full-range values
  function automatic coord_t pick_coord();
    coord_t v;
    case ($urandom_range(0, 7))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2: v = coord_t'($urandom_range(0, 1023)) - 16'sd512;
      default: v = coord_t'($urandom());
    endcase
    return v;
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    c.start_x     = pick_coord();
    c.start_y     = pick_coord();
    c.start_tan_x = pick_coord();
    c.start_tan_y = pick_coord();
    c.end_x       = pick_coord();
    c.end_y       = pick_coord();
    c.end_tan_x   = pick_coord();
    c.end_tan_y   = pick_coord();
    return c;
  endfunction

  function automatic curve_t fill_curve(input coord_t px, input coord_t tx0, input coord_t tx1);
    curve_t c;
    c.start_x     = px;
    c.start_y     = px;
    c.start_tan_x = tx0;
    c.start_tan_y = tx0;
    c.end_x       = px;
    c.end_y       = px;
    c.end_tan_x   = tx1;
    c.end_tan_y   = tx1;
    return c;
  endfunction

  // Check each output beat against the oldest queued pixel; randomize ready
  always @(posedge clk) begin : rx_check
    pixel_t got;
    pixel_t want;
    m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got.x    = m_tdata[CW-1:0];
      got.y    = m_tdata[2*CW-1:CW];
      got.rgb  = m_tdata[2*CW+COLOR_W-1:2*CW];
      got.last = m_tlast;
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected beat, x", longint'(got.x), 0);
      end else begin
        want = pixel_q.pop_front();
        if (got.x !== want.x) begin
          report_mismatch("pixel_x", longint'(got.x), longint'(want.x));
        end
        if (got.y !== want.y) begin
          report_mismatch("pixel_y", longint'(got.y), longint'(want.y));
        end
        if (got.rgb !== want.rgb) begin
          report_mismatch("pixel_rgb", longint'(got.rgb), longint'(want.rgb));
        end
        if (got.last !== want.last) begin
          report_mismatch("last_point", longint'(got.last), longint'(want.last));
        end
      end
      pixels_seen++;
    end
  end

  // End the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ERROR no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Curves under the reset configuration: 16 points, color zero
  task automatic test_reset_config();
    send_curve(fill_curve(16'sd0, 16'sd0, 16'sd0));
    send_curve(random_curve());
    send_curve(random_curve());
    tx_stop();
    wait_drained();
  endtask

  // Shortest run, no-output counts, longest run and counts past the cap
  task automatic test_point_counts();
    int counts[7] = '{2, 0, 1, 3, 64, 65, 127};
    foreach (counts[k]) begin
      set_config(CFG_DATA_W'(counts[k]), (k % 2) ? 24'hFFFFFF : 24'(k));
      send_curve(random_curve());
      if (counts[k] < 2) send_curve(random_curve());
      tx_stop();
      wait_drained();
    end
  endtask

  // Rails, overshoot into saturation both ways, alternating bit patterns
  task automatic test_coordinate_extremes();
    curve_t c;
    // upper bits of the num_points word are set and must be ignored
    set_config(24'hFFFF89, 24'hFFFFFF);
    send_curve(fill_curve(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    send_curve(fill_curve(16'sh8000, 16'sh8000, 16'sh8000));
    send_curve(fill_curve(16'sh7FFF, 16'sh7FFF, 16'sh8000));
    send_curve(fill_curve(16'sh8000, 16'sh8000, 16'sh7FFF));
    send_curve(fill_curve(16'sh0000, 16'sh7FFF, 16'sh7FFF));
    c = {4{16'sh5555, 16'shAAAA}};
    send_curve(c);
    c = {4{16'shAAAA, 16'sh5555}};
    send_curve(c);
    tx_stop();
    wait_drained();
  endtask

  // Random curves in blocks, with a fresh configuration before each block
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int per_block);
    logic [CFG_DATA_W-1:0] np_word;
    int                    pick;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int blk = 0; blk < 3; blk++) begin
      pick    = $urandom_range(0, 99);
      np_word = CFG_DATA_W'($urandom());
      if (pick < 5) begin
        np_word[NP_W-1:0] = NP_W'($urandom_range(0, 1));
      end else if (pick < 8) begin
        np_word[NP_W-1:0] = NP_W'($urandom_range(64, 127));
      end else begin
        np_word[NP_W-1:0] = NP_W'($urandom_range(2, 10));
      end
      set_config(np_word, COLOR_W'($urandom()));
      for (int k = 0; k < per_block; k++) begin
        send_curve(random_curve());
      end
      tx_stop();
      wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_point_counts();
    test_coordinate_extremes();
    test_random_traffic(0, 0, 29);
    test_random_traffic(88, 0, 29);
    test_random_traffic(0, 88, 29);
    test_random_traffic(9, 9, 29);

    $display("Sent %0d curves under %0d register settings, checked %0d pixels.",
             curves_sent, settings, pixels_seen);
    $display("Point counts 0..127, rail and saturating coordinates, four idle/stall mixes.");
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d pixels still owed", mismatches, pixel_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/hcpg_pkg.sv
rtl/core/hermite_curve_point_generator.sv
bench/hermite_curve_point_generator_test.sv
